// ----- rtl/lpr_pkg.sv -----
// Shared definitions for the line pixel rasterizer.
// Request codes and the flag group passed from the setup and step logic to the top level.
package lpr_pkg;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef struct packed {
    logic diag;
    logic last;
  } lpr_flags_t;

endpackage

// ----- rtl/lpr_setup.sv -----
// Line setup: deltas, major axis, start point and decision terms for a new line.
// Purely combinational; uses lpr_pkg for the flag group.
module lpr_setup import lpr_pkg::*; #(
  parameter int CoordBits = 11
) (
  input  logic [CoordBits-1:0] x_start,
  input  logic [CoordBits-1:0] y_start,
  input  logic [CoordBits-1:0] x_end,
  input  logic [CoordBits-1:0] y_end,
  output logic [CoordBits-1:0] first_x,
  output logic [CoordBits-1:0] first_y,
  output logic [CoordBits-1:0] major_end,
  output logic [CoordBits+1:0] decision,
  output logic [CoordBits+1:0] inc_straight,
  output logic [CoordBits+1:0] inc_diagonal,
  output logic                 minor_down,
  output logic                 x_major,
  output lpr_flags_t           flags
);

  logic [CoordBits-1:0] dx;
  logic [CoordBits-1:0] dy;
  logic [CoordBits-1:0] dmaj;
  logic [CoordBits-1:0] dmin;
  logic [CoordBits-1:0] end_minor;
  logic [CoordBits+1:0] twice_min;
  logic [CoordBits+1:0] twice_maj;

  always_comb begin
    dx = (x_end > x_start) ? x_end - x_start : x_start - x_end;
    dy = (y_end > y_start) ? y_end - y_start : y_start - y_end;
    x_major = dx > dy;
    if (x_major) begin
      dmaj = dx;
      dmin = dy;
      if (x_start > x_end) begin
        first_x   = x_end;
        first_y   = y_end;
        major_end = x_start;
        end_minor = y_start;
      end else begin
        first_x   = x_start;
        first_y   = y_start;
        major_end = x_end;
        end_minor = y_end;
      end
      minor_down = first_y > end_minor;
      flags.last = first_x == major_end;
    end else begin
      dmaj = dy;
      dmin = dx;
      if (y_start > y_end) begin
        first_x   = x_end;
        first_y   = y_end;
        major_end = y_start;
        end_minor = x_start;
      end else begin
        first_x   = x_start;
        first_y   = y_start;
        major_end = y_end;
        end_minor = x_end;
      end
      minor_down = first_x > end_minor;
      flags.last = first_y == major_end;
    end
    flags.diag   = 1'b0;
    twice_min    = {1'b0, dmin, 1'b0};
    twice_maj    = {1'b0, dmaj, 1'b0};
    inc_straight = twice_min;
    inc_diagonal = twice_min - twice_maj;
    decision     = twice_min - {2'b00, dmaj};
  end

endmodule

// ----- rtl/lpr_step.sv -----
// Line step: advance one pixel along the major axis and update the decision term.
// Purely combinational; uses lpr_pkg for the flag group.
module lpr_step import lpr_pkg::*; #(
  parameter int CoordBits = 11
) (
  input  logic [CoordBits-1:0] cur_x,
  input  logic [CoordBits-1:0] cur_y,
  input  logic [CoordBits-1:0] major_end,
  input  logic [CoordBits+1:0] decision,
  input  logic [CoordBits+1:0] inc_straight,
  input  logic [CoordBits+1:0] inc_diagonal,
  input  logic                 minor_down,
  input  logic                 x_major,
  output logic [CoordBits-1:0] cur_x_next,
  output logic [CoordBits-1:0] cur_y_next,
  output logic [CoordBits+1:0] decision_next,
  output lpr_flags_t           flags
);

  logic [CoordBits-1:0] minor_step;

  always_comb begin
    flags.diag = ~decision[CoordBits+1];
    minor_step = minor_down ? {CoordBits{1'b1}} : {{(CoordBits-1){1'b0}}, 1'b1};
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (x_major) begin
      cur_x_next = cur_x + {{(CoordBits-1){1'b0}}, 1'b1};
      if (flags.diag) begin
        cur_y_next = cur_y + minor_step;
      end
      flags.last = cur_x_next == major_end;
    end else begin
      cur_y_next = cur_y + {{(CoordBits-1){1'b0}}, 1'b1};
      if (flags.diag) begin
        cur_x_next = cur_x + minor_step;
      end
      flags.last = cur_y_next == major_end;
    end
    decision_next = decision + (flags.diag ? inc_diagonal : inc_straight);
  end

endmodule

// ----- rtl/line_pixel_rasterizer.sv -----
// Bresenham line rasterizer, all octants, at most one pixel per request.
// A request is registered in the staging stage; its pixel is then registered at the output.
// Throughput: one request per cycle unless pix_ready stalls the output; set by the add and compare on line state.
// Step requests while no line is active produce no pixel and pass without waiting on the pixel output.
// Reset (rst, synchronous) empties both stages and leaves the rasterizer idle.
// Depends on lpr_pkg, lpr_setup and lpr_step.
module line_pixel_rasterizer import lpr_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  pix_valid,
  input  logic                  pix_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);

  localparam int DW = COORD_BITS + 2;

  logic                  stg_valid;
  logic                  stg_type;
  logic [COORD_BITS-1:0] stg_xs;
  logic [COORD_BITS-1:0] stg_ys;
  logic [COORD_BITS-1:0] stg_xe;
  logic [COORD_BITS-1:0] stg_ye;

  logic                  busy;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] major_end;
  logic [DW-1:0]         decision;
  logic [DW-1:0]         inc_straight;
  logic [DW-1:0]         inc_diagonal;
  logic                  minor_down;
  logic                  x_major;

  logic [COORD_BITS-1:0] su_x;
  logic [COORD_BITS-1:0] su_y;
  logic [COORD_BITS-1:0] su_major_end;
  logic [DW-1:0]         su_decision;
  logic [DW-1:0]         su_inc_straight;
  logic [DW-1:0]         su_inc_diagonal;
  logic                  su_minor_down;
  logic                  su_x_major;
  lpr_flags_t            su_flags;

  logic [COORD_BITS-1:0] cur_x_next;
  logic [COORD_BITS-1:0] cur_y_next;
  logic [DW-1:0]         decision_next;
  lpr_flags_t            st_flags;

  logic                  is_start;
  logic                  produce;
  logic                  stg_fire;
  logic                  new_last;

  lpr_setup #(.CoordBits(COORD_BITS)) u_setup (
    .x_start      (stg_xs),
    .y_start      (stg_ys),
    .x_end        (stg_xe),
    .y_end        (stg_ye),
    .first_x      (su_x),
    .first_y      (su_y),
    .major_end    (su_major_end),
    .decision     (su_decision),
    .inc_straight (su_inc_straight),
    .inc_diagonal (su_inc_diagonal),
    .minor_down   (su_minor_down),
    .x_major      (su_x_major),
    .flags        (su_flags)
  );

  lpr_step #(.CoordBits(COORD_BITS)) u_step (
    .cur_x         (cur_x),
    .cur_y         (cur_y),
    .major_end     (major_end),
    .decision      (decision),
    .inc_straight  (inc_straight),
    .inc_diagonal  (inc_diagonal),
    .minor_down    (minor_down),
    .x_major       (x_major),
    .cur_x_next    (cur_x_next),
    .cur_y_next    (cur_y_next),
    .decision_next (decision_next),
    .flags         (st_flags)
  );

  assign is_start  = stg_type == REQ_START;
  assign produce   = stg_valid && (is_start || busy);
  assign stg_fire  = stg_valid && (!produce || !pix_valid || pix_ready);
  assign req_ready = !stg_valid || stg_fire;
  assign new_last  = is_start ? su_flags.last : st_flags.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req_ready) begin
      stg_valid <= req_valid;
    end
    if (req_valid && req_ready) begin
      stg_type <= req_type;
      stg_xs   <= x_start;
      stg_ys   <= y_start;
      stg_xe   <= x_end;
      stg_ye   <= y_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      major_end    <= '0;
      decision     <= '0;
      inc_straight <= '0;
      inc_diagonal <= '0;
      minor_down   <= 1'b0;
      x_major      <= 1'b0;
    end else if (stg_fire && produce) begin
      busy <= !new_last;
      if (is_start) begin
        cur_x        <= su_x;
        cur_y        <= su_y;
        major_end    <= su_major_end;
        decision     <= su_decision;
        inc_straight <= su_inc_straight;
        inc_diagonal <= su_inc_diagonal;
        minor_down   <= su_minor_down;
        x_major      <= su_x_major;
      end else begin
        cur_x    <= cur_x_next;
        cur_y    <= cur_y_next;
        decision <= decision_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (stg_fire && produce) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
    if (stg_fire && produce) begin
      pixel_x    <= is_start ? su_x : cur_x_next;
      pixel_y    <= is_start ? su_y : cur_y_next;
      last_pixel <= new_last;
    end
  end

  a_last_clears_busy: assert property (@(posedge clk) disable iff (rst)
    (stg_fire && produce && new_last) |=> !busy)
    else $error("line still active after its final pixel");

  a_busy_not_at_end: assert property (@(posedge clk) disable iff (rst)
    busy |-> (x_major ? (cur_x != major_end) : (cur_y != major_end)))
    else $error("line active with major coordinate at its end");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (stg_fire && !produce && pix_valid && pix_ready) |=> !pix_valid)
    else $error("step request without active line produced a pixel");

  a_pixel_matches_state: assert property (@(posedge clk) disable iff (rst)
    (stg_fire && produce) |=> (pixel_x == cur_x && pixel_y == cur_y && last_pixel == !busy))
    else $error("presented pixel differs from line state");

endmodule
